// File: hdl/spi_pio_pkg.sv
// ----------------------------------------------------------------------------
// spi_pio_pkg
// Shared constants, register offsets and types for the serial flash
// controller PIO register block.
// ----------------------------------------------------------------------------
package spi_pio_pkg;

    // Stream widths (tdata fields packed from bit 0 up, padded to whole bytes)
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    localparam int DEF_FIFO_DEPTH = 16;

    // Request kinds carried on tuser
    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_RESTORE = 2'd2;

    // Register offsets
    localparam logic [13:0] OFF_CTRL0     = 14'h000;
    localparam logic [13:0] OFF_CTRL1     = 14'h004;
    localparam logic [13:0] OFF_ENABLE    = 14'h008;
    localparam logic [13:0] OFF_TX_LEVEL  = 14'h020;
    localparam logic [13:0] OFF_RX_LEVEL  = 14'h024;
    localparam logic [13:0] OFF_STATUS    = 14'h028;
    localparam logic [13:0] OFF_ZERO_LO   = 14'h030;
    localparam logic [13:0] OFF_ZERO_HI   = 14'h048;
    localparam logic [13:0] OFF_ID        = 14'h058;
    localparam logic [13:0] OFF_VERSION   = 14'h05C;
    localparam logic [13:0] OFF_SPI_CTRL  = 14'h0F4;
    localparam logic [13:0] WIN_LO        = 14'h060;
    localparam logic [13:0] WIN_HI        = 14'h0E0;

    localparam int NUM_MISC = 11;
    localparam logic [13:0] MISC_OFFS [NUM_MISC] = '{
        14'h00C, 14'h010, 14'h014, 14'h018, 14'h01C, 14'h02C,
        14'h04C, 14'h050, 14'h054, 14'h0F0, 14'h0F8
    };

    localparam logic [31:0] ID_WORD       = 32'h5153_5049;
    localparam logic [31:0] VERSION_WORD  = 32'h3430_312A;
    localparam logic [31:0] CMD_MODE_CTRL = 32'(7) << 16;

    // Frame-size field of control register zero
    localparam int DFS_LSB = 16;
    localparam int DFS_W   = 5;

    // FIFO control between register decode and receive FIFO
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

// File: hdl/spi_controller_pio_registers_unit.sv
// ----------------------------------------------------------------------------
// spi_controller_pio_registers_unit
// Input register, then result register, between input beat and result beat;
// throughput: one beat per cycle while the result side does not stall.
// Reset (rst_n, async low) clears the handshake state, the control registers
// (control zero back to 8-bit frames) and the receive FIFO pointers.
// ----------------------------------------------------------------------------
//
// Register block of a serial flash controller, programmed-IO path. Each input
// beat is a bus read, a bus write or a command-mode restore. Writes to the
// data window shift out one frame of 1 to 4 bytes and push the masked reply
// into the receive FIFO; reads of the window pop it. Clearing bit 0 of the
// enable register releases chip select and empties the FIFO.
//
// Pipeline:
//   stage 1 : input register (request kind, offset, write data, reply)
//   decode  : register file read/write, FIFO push/pop, frame masking
//   stage 2 : result register, drained by the master-side handshake
// The FIFO head word is read ahead into a register, so it is ready for a pop.
module spi_controller_pio_registers_unit
    import spi_pio_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [13:0] offset, [45:14] write_data, [77:46] reply_frame, [79:78] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // Result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] read_data, [32] frame_sent, [64:33] frame_word,
    // [67:65] frame_length, [68] deselect, [69] rx_overflow, [70] unmapped,
    // [71] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    // ---------------------------------------------------------------- stage 1
    logic        in_valid_reg;
    logic [1:0]  req_reg;
    logic [13:0] off_reg;
    logic [31:0] wdata_reg;
    logic [31:0] reply_reg;

    logic        advance;   // result register can take a beat this cycle
    logic        proc;      // the held request is decoded this cycle

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg   <= s_axis_tuser[1:0];
            off_reg   <= s_axis_tdata[13:0];
            wdata_reg <= s_axis_tdata[45:14];
            reply_reg <= s_axis_tdata[77:46];
        end
    end

    // -------------------------------------------------------- register file
    logic [31:0] ctrl0_reg,    ctrl0_next;
    logic [31:0] ctrl1_reg,    ctrl1_next;
    logic [31:0] enable_reg,   enable_next;
    logic [31:0] spi_ctrl_reg, spi_ctrl_next;
    logic [31:0] misc_reg  [NUM_MISC];
    logic [31:0] misc_next [NUM_MISC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg    <= CMD_MODE_CTRL;
            ctrl1_reg    <= '0;
            enable_reg   <= '0;
            spi_ctrl_reg <= '0;
            for (int k = 0; k < NUM_MISC; k++)
            begin
                misc_reg[k] <= '0;
            end
        end
        else
        begin
            ctrl0_reg    <= ctrl0_next;
            ctrl1_reg    <= ctrl1_next;
            enable_reg   <= enable_next;
            spi_ctrl_reg <= spi_ctrl_next;
            for (int k = 0; k < NUM_MISC; k++)
            begin
                misc_reg[k] <= misc_next[k];
            end
        end
    end

    // ------------------------------------------------------- frame sizing
    // Bytes = ceil((dfs + 1) / 8); a field below 3 means 8-bit frames.
    logic [DFS_W-1:0] dfs;
    logic [DFS_W:0]   dfs_sum;
    logic [2:0]       dfs_bytes;
    logic [31:0]      frame_mask;

    assign dfs       = ctrl0_reg[DFS_LSB +: DFS_W];
    assign dfs_sum   = {1'b0, dfs} + (DFS_W+1)'(8);
    assign dfs_bytes = (dfs < DFS_W'(3)) ? 3'd1 : dfs_sum[DFS_W:3];

    always_comb
    begin
        case (dfs_bytes)
            3'd1:    frame_mask = 32'h0000_00FF;
            3'd2:    frame_mask = 32'h0000_FFFF;
            3'd3:    frame_mask = 32'h00FF_FFFF;
            default: frame_mask = 32'hFFFF_FFFF;
        endcase
    end

    // ---------------------------------------------------------- receive FIFO
    fifo_ctrl_t       fifo_ctrl;
    logic [LVL_W-1:0] rx_level;
    logic [31:0]      rx_head;
    logic             rx_empty;
    logic             rx_full;

    spi_pio_rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_data (reply_reg & frame_mask),
        .level     (rx_level),
        .head_data (rx_head)
    );

    assign rx_empty = (rx_level == '0);
    assign rx_full  = (rx_level == LVL_W'(FIFO_DEPTH));

    // --------------------------------------------------------------- decode
    logic        misc_hit;
    logic [31:0] misc_rd;
    logic        in_window;
    logic [31:0] read_data;
    logic        frame_sent;
    logic [31:0] frame_word;
    logic [2:0]  frame_length;
    logic        deselect;
    logic        rx_overflow;
    logic        unmapped;

    assign in_window = (off_reg >= WIN_LO) && (off_reg < WIN_HI);

    always_comb
    begin
        misc_hit = 1'b0;
        misc_rd  = '0;
        for (int k = 0; k < NUM_MISC; k++)
        begin
            if (off_reg == MISC_OFFS[k])
            begin
                misc_hit = 1'b1;
                misc_rd  = misc_rd | misc_reg[k];
            end
        end
    end

    always_comb
    begin
        ctrl0_next    = ctrl0_reg;
        ctrl1_next    = ctrl1_reg;
        enable_next   = enable_reg;
        spi_ctrl_next = spi_ctrl_reg;
        for (int k = 0; k < NUM_MISC; k++)
        begin
            misc_next[k] = misc_reg[k];
        end
        fifo_ctrl    = '0;
        read_data    = '0;
        frame_sent   = 1'b0;
        frame_word   = '0;
        frame_length = '0;
        deselect     = 1'b0;
        rx_overflow  = 1'b0;
        unmapped     = 1'b0;

        if (proc)
        begin
            case (req_reg)
                REQ_READ:
                begin
                    if (misc_hit)
                    begin
                        read_data = misc_rd;
                    end
                    else
                    begin
                        case (off_reg)
                            OFF_CTRL0:    read_data = ctrl0_reg;
                            OFF_CTRL1:    read_data = ctrl1_reg;
                            OFF_ENABLE:   read_data = enable_reg;
                            OFF_TX_LEVEL: read_data = '0;
                            OFF_RX_LEVEL: read_data = 32'(rx_level);
                            OFF_STATUS:   read_data = {27'd0, rx_full, !rx_empty, 2'b11, 1'b0};
                            OFF_ID:       read_data = ID_WORD;
                            OFF_VERSION:  read_data = VERSION_WORD;
                            OFF_SPI_CTRL: read_data = spi_ctrl_reg;
                            default:
                            begin
                                if (off_reg inside {OFF_ZERO_LO, 14'h034, 14'h038, 14'h03C,
                                                    14'h040, 14'h044, OFF_ZERO_HI})
                                begin
                                    read_data = '0;
                                end
                                else if (in_window)
                                begin
                                    // empty window read gives zero, no pop
                                    if (!rx_empty)
                                    begin
                                        read_data     = rx_head;
                                        fifo_ctrl.pop = 1'b1;
                                    end
                                end
                                else
                                begin
                                    unmapped = 1'b1;
                                end
                            end
                        endcase
                    end
                end

                REQ_WRITE:
                begin
                    if (misc_hit)
                    begin
                        for (int k = 0; k < NUM_MISC; k++)
                        begin
                            if (off_reg == MISC_OFFS[k])
                            begin
                                misc_next[k] = wdata_reg;
                            end
                        end
                    end
                    else
                    begin
                        case (off_reg)
                            OFF_CTRL0:    ctrl0_next    = wdata_reg;
                            OFF_CTRL1:    ctrl1_next    = wdata_reg;
                            OFF_SPI_CTRL: spi_ctrl_next = wdata_reg;
                            OFF_ENABLE:
                            begin
                                enable_next = wdata_reg;
                                // enable falling: release chip select, flush
                                if (enable_reg[0] && !wdata_reg[0])
                                begin
                                    deselect        = 1'b1;
                                    fifo_ctrl.clear = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (in_window)
                                begin
                                    frame_sent   = 1'b1;
                                    frame_word   = wdata_reg & frame_mask;
                                    frame_length = dfs_bytes;
                                    if (rx_full)
                                    begin
                                        rx_overflow = 1'b1;
                                    end
                                    else
                                    begin
                                        fifo_ctrl.push = 1'b1;
                                    end
                                end
                                else
                                begin
                                    unmapped = 1'b1;
                                end
                            end
                        endcase
                    end
                end

                REQ_RESTORE:
                begin
                    ctrl0_next      = CMD_MODE_CTRL;
                    spi_ctrl_next   = '0;
                    enable_next     = 32'd1;
                    fifo_ctrl.clear = 1'b1;
                end

                default:
                begin
                    // unused request kind: no effect, all-zero result
                end
            endcase
        end
    end

    // -------------------------------------------------------------- stage 2
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= {1'b0, unmapped, rx_overflow, deselect, frame_length,
                             frame_word, frame_sent, read_data};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: hdl/spi_pio_rx_fifo.sv
// ----------------------------------------------------------------------------
// spi_pio_rx_fifo
// Receive FIFO with a registered look-ahead read of the head entry, so the
// head word is ready in the cycle an access pops it.
// ----------------------------------------------------------------------------
module spi_pio_rx_fifo
    import spi_pio_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    localparam int PTR_W = $clog2(FIFO_DEPTH),
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fifo_ctrl_t       ctrl,
    input  logic [31:0]      push_data,
    output logic [LVL_W-1:0] level,
    output logic [31:0]      head_data
);

    localparam int SUM_W = PTR_W + 1;

    logic [31:0]      rx_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [31:0]      head_data_reg;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;

    // tail = (head + level) mod depth; the sum stays below twice the depth
    assign wr_sum  = {1'b0, head_reg} + SUM_W'(level_reg);
    assign wr_addr = (wr_sum >= SUM_W'(FIFO_DEPTH)) ?
                     PTR_W'(wr_sum - SUM_W'(FIFO_DEPTH)) : wr_sum[PTR_W-1:0];

    always_comb
    begin
        head_next  = head_reg;
        level_next = level_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            level_next = '0;
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            level_next = level_reg - 1'b1;
        end
        else if (ctrl.push)
        begin
            level_next = level_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            level_reg <= level_next;
        end
    end

    // Storage and look-ahead read of the next head entry, with write bypass
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            rx_mem[wr_addr] <= push_data;
        end
        if (ctrl.push && (wr_addr == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= rx_mem[head_next];
        end
    end

    assign level     = level_reg;
    assign head_data = head_data_reg;

endmodule

// File: dv/spi_controller_pio_registers_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_controller_pio_registers_unit_tb
// Self-checking bench for the PIO register block: bus reads, bus writes and
// command-mode restores go in on the request stream. A cycle-free copy of the
// register file and receive FIFO predicts every result beat. The results are
// checked field by field, in order, while both streams stall at random.
// ----------------------------------------------------------------------------
module spi_controller_pio_registers_unit_tb;
    import spi_pio_pkg::*;

    localparam logic [1:0]  REQ_UNUSED     = 2'd3;
    localparam logic [31:0] STAT_FIXED     = 32'h0000_0006;
    localparam logic [31:0] STAT_RX_NEMPTY = 32'h0000_0008;
    localparam logic [31:0] STAT_RX_FULL   = 32'h0000_0010;
    localparam logic [31:0] ENABLE_BIT     = 32'h0000_0001;
    localparam int          MAX_REPORTS    = 40;

    localparam logic [13:0] CORE_OFFS [9] = '{
        OFF_CTRL0, OFF_CTRL1, OFF_ENABLE, OFF_TX_LEVEL, OFF_RX_LEVEL,
        OFF_STATUS, OFF_ID, OFF_VERSION, OFF_SPI_CTRL
    };

    // Result beat as laid out on m_axis_tdata[70:0]
    typedef struct packed {
        logic        unmapped;
        logic        rx_overflow;
        logic        deselect;
        logic [2:0]  frame_length;
        logic [31:0] frame_word;
        logic        frame_sent;
        logic [31:0] read_data;
    } pio_result_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the register file and receive FIFO
    logic [31:0] ctrl0_q;
    logic [31:0] ctrl1_q;
    logic [31:0] enable_q;
    logic [31:0] spi_ctrl_q;
    logic [31:0] misc_q [NUM_MISC];
    logic [31:0] rx_mem [DEF_FIFO_DEPTH];
    int          rx_head;
    int          rx_fill;

    pio_result_t pending_results [$];
    int          mismatch_count   = 0;
    int          results_seen     = 0;
    int          beats_sent       = 0;
    int          burst_left       = 1;
    bit          pacing_on        = 1'b1;
    int          sink_hold_cycles = 0;

    spi_controller_pio_registers_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("spi_controller_pio_registers_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: applies one access to the shadow state, returns the beat
    // ------------------------------------------------------------------
    function automatic pio_result_t predict_access(logic [1:0] kind, logic [13:0] off,
                                                   logic [31:0] wdata, logic [31:0] reply);
        pio_result_t r;
        int          slot;
        int          i;
        int          bits;
        int          nbytes;
        logic [31:0] mask;
        bit          in_window;
        r         = '0;
        slot      = -1;
        for (i = 0; i < NUM_MISC; i++)
            if (MISC_OFFS[i] == off)
                slot = i;
        in_window = (off >= WIN_LO) && (off < WIN_HI);

        case (kind)
            REQ_READ:
            begin
                if (slot >= 0)
                    r.read_data = misc_q[slot];
                else if (off == OFF_CTRL0)
                    r.read_data = ctrl0_q;
                else if (off == OFF_CTRL1)
                    r.read_data = ctrl1_q;
                else if (off == OFF_ENABLE)
                    r.read_data = enable_q;
                else if (off == OFF_TX_LEVEL)
                    r.read_data = '0;
                else if (off == OFF_RX_LEVEL)
                    r.read_data = 32'(rx_fill);
                else if (off == OFF_STATUS)
                begin
                    r.read_data = STAT_FIXED;
                    if (rx_fill != 0)
                        r.read_data |= STAT_RX_NEMPTY;
                    if (rx_fill >= DEF_FIFO_DEPTH)
                        r.read_data |= STAT_RX_FULL;
                end
                else if (off >= OFF_ZERO_LO && off <= OFF_ZERO_HI && off[1:0] == 2'b00)
                    r.read_data = '0;
                else if (off == OFF_ID)
                    r.read_data = ID_WORD;
                else if (off == OFF_VERSION)
                    r.read_data = VERSION_WORD;
                else if (off == OFF_SPI_CTRL)
                    r.read_data = spi_ctrl_q;
                else if (in_window)
                begin
                    // empty FIFO reads as zero and leaves the pointers alone
                    if (rx_fill != 0)
                    begin
                        r.read_data = rx_mem[rx_head];
                        rx_head     = (rx_head + 1) % DEF_FIFO_DEPTH;
                        rx_fill--;
                    end
                end
                else
                    r.unmapped = 1'b1;
            end
            REQ_WRITE:
            begin
                if (slot >= 0)
                    misc_q[slot] = wdata;
                else if (off == OFF_CTRL0)
                    ctrl0_q = wdata;
                else if (off == OFF_CTRL1)
                    ctrl1_q = wdata;
                else if (off == OFF_ENABLE)
                begin
                    // falling enable releases chip select and drops the FIFO
                    if (enable_q[0] && !wdata[0])
                    begin
                        r.deselect = 1'b1;
                        rx_head    = 0;
                        rx_fill    = 0;
                    end
                    enable_q = wdata;
                end
                else if (off == OFF_SPI_CTRL)
                    spi_ctrl_q = wdata;
                else if (in_window)
                begin
                    bits = int'(ctrl0_q[DFS_LSB +: DFS_W]) + 1;
                    if (bits < 4)
                        bits = 8;
                    nbytes         = (bits + 7) / 8;
                    mask           = (nbytes >= 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * nbytes)) - 1;
                    r.frame_sent   = 1'b1;
                    r.frame_word   = wdata & mask;
                    r.frame_length = 3'(nbytes);
                    if (rx_fill >= DEF_FIFO_DEPTH)
                        r.rx_overflow = 1'b1;
                    else
                    begin
                        rx_mem[(rx_head + rx_fill) % DEF_FIFO_DEPTH] = reply & mask;
                        rx_fill++;
                    end
                end
                else
                    r.unmapped = 1'b1;
            end
            REQ_RESTORE:
            begin
                ctrl0_q    = CMD_MODE_CTRL;
                spi_ctrl_q = '0;
                enable_q   = ENABLE_BIT;
                rx_head    = 0;
                rx_fill    = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Caller sits just past a rising edge. valid stays high into the next
    // call when the burst goes on, so it is never dropped and raised in one step.
    task automatic send_beat(logic [1:0] kind, logic [13:0] off,
                             logic [31:0] wdata, logic [31:0] reply);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, reply, wdata, off};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_access(kind, off, wdata, reply));
        beats_sent++;
        if (pacing_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Sender pauses until every predicted beat has come back
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [13:0] random_offset();
        case ($urandom_range(0, 9))
            0, 1, 2: return 14'($urandom_range(WIN_LO, WIN_HI - 1));
            3, 4:    return MISC_OFFS[$urandom_range(0, NUM_MISC - 1)];
            5:       return OFF_ZERO_LO + 14'(4 * $urandom_range(0, 6));
            6, 7:    return CORE_OFFS[$urandom_range(0, 8)];
            8:       return 14'($urandom);
            default: return 14'($urandom_range(0, 14'h0FF));   // often unaligned
        endcase
    endfunction

    // control zero with a random frame-size field, full range of sizes
    function automatic logic [31:0] random_ctrl0();
        logic [31:0] v;
        v                     = $urandom;
        v[DFS_LSB +: DFS_W]   = DFS_W'($urandom_range(0, 31));
        return v;
    endfunction

    // Enable, optionally resize, then a run of frames, pops and level or status reads; maybe disable
    task automatic run_frame_session();
        int n;
        send_beat(REQ_WRITE, OFF_ENABLE, $urandom | ENABLE_BIT, $urandom);
        if ($urandom_range(0, 2) == 0)
            send_beat(REQ_WRITE, OFF_CTRL0, random_ctrl0(), $urandom);
        n = $urandom_range(1, 24);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    send_beat(REQ_WRITE, 14'($urandom_range(WIN_LO, WIN_HI - 1)),
                              $urandom, $urandom);
                6, 7, 8:
                    send_beat(REQ_READ, 14'($urandom_range(WIN_LO, WIN_HI - 1)),
                              $urandom, $urandom);
                default:
                    send_beat(REQ_READ, $urandom_range(0, 1) ? OFF_STATUS : OFF_RX_LEVEL,
                              $urandom, $urandom);
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            send_beat(REQ_WRITE, OFF_ENABLE, $urandom & ~ENABLE_BIT, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        send_beat(REQ_READ,  OFF_CTRL0,   '0, '0);          // reset frame size
        send_beat(REQ_READ,  OFF_ID,      '0, '0);
        send_beat(REQ_READ,  OFF_VERSION, '0, '0);
        send_beat(REQ_READ,  OFF_STATUS,  '0, '0);
        send_beat(REQ_READ,  WIN_LO,      '0, '0);          // pop from empty FIFO
        send_beat(REQ_WRITE, OFF_CTRL0,   32'hFFFF_FFFF, '0);  // 32-bit frames
        send_beat(REQ_WRITE, WIN_LO,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(REQ_WRITE, OFF_CTRL0,   32'h0001_0000, '1);  // short field -> 1 byte
        send_beat(REQ_WRITE, WIN_HI - 1,  32'hA5C3_7E81, 32'h1234_5678);
        send_beat(REQ_WRITE, OFF_CTRL0,   32'h000F_0000, '0);  // 16-bit frames
        send_beat(REQ_WRITE, 14'h0077,    32'hDEAD_BEEF, 32'hCAFE_F00D);
        send_beat(REQ_READ,  OFF_RX_LEVEL,'0, '0);
        send_beat(REQ_READ,  14'h0061,    '0, '0);
        send_beat(REQ_WRITE, OFF_ENABLE,  ENABLE_BIT, '0);
        send_beat(REQ_WRITE, OFF_ENABLE,  '0, '0);          // falling enable
        send_beat(REQ_READ,  WIN_LO,      '0, '0);
        send_beat(REQ_WRITE, OFF_ID,      '1, '1);          // read-only target
        send_beat(REQ_WRITE, 14'h3FFF,    '1, '1);
        send_beat(REQ_READ,  14'h3FFF,    '1, '1);
        send_beat(REQ_READ,  14'h0001,    '0, '0);          // unaligned outside window
        send_beat(REQ_WRITE, OFF_SPI_CTRL,'1, '0);
        send_beat(REQ_RESTORE, 14'h3FFF,  '1, '1);
        send_beat(REQ_READ,  OFF_SPI_CTRL,'0, '0);
        send_beat(REQ_READ,  OFF_ENABLE,  '0, '0);
        send_beat(REQ_UNUSED, 14'h3FFF,   '1, '1);
        quiesce();
    endtask

    task automatic test_rx_overflow();
        send_beat(REQ_WRITE, OFF_ENABLE, ENABLE_BIT, $urandom);
        send_beat(REQ_WRITE, OFF_CTRL0, random_ctrl0(), $urandom);
        repeat (DEF_FIFO_DEPTH + 4)
            send_beat(REQ_WRITE, 14'($urandom_range(WIN_LO, WIN_HI - 1)), $urandom, $urandom);
        send_beat(REQ_READ, OFF_STATUS, $urandom, $urandom);
        send_beat(REQ_READ, OFF_RX_LEVEL, $urandom, $urandom);
        repeat (DEF_FIFO_DEPTH + 2)
            send_beat(REQ_READ, 14'($urandom_range(WIN_LO, WIN_HI - 1)), $urandom, $urandom);
        send_beat(REQ_READ, OFF_STATUS, $urandom, $urandom);
        quiesce();
    endtask

    // Result side holds off while requests keep coming, so the block backs up
    task automatic test_backpressure();
        pacing_on        = 1'b0;
        sink_hold_cycles = 80;
        send_beat(REQ_WRITE, OFF_ENABLE, ENABLE_BIT, $urandom);
        repeat (48)
        begin
            if ($urandom_range(0, 2) == 0)
                send_beat(REQ_READ, random_offset(), $urandom, $urandom);
            else
                send_beat(REQ_WRITE, 14'($urandom_range(WIN_LO, WIN_HI - 1)),
                          $urandom, $urandom);
        end
        pacing_on = 1'b1;
        quiesce();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = beats_sent + 1100;
        while (beats_sent < stop_at)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                    run_frame_session();
                10, 11, 12, 13, 14:
                    repeat ($urandom_range(1, 8))
                        send_beat(2'($urandom_range(0, 1)), random_offset(), $urandom, $urandom);
                15, 16, 17:
                    send_beat(2'($urandom_range(0, 3)), 14'($urandom), $urandom, $urandom);
                default:
                begin
                    send_beat(REQ_RESTORE, random_offset(), $urandom, $urandom);
                    run_frame_session();
                end
            endcase
            if ($urandom_range(0, 29) == 0)
                quiesce();
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------
    initial
    begin : sink_pacer
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;                       // no stalls
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                endcase
            end
        end
    end

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: result beat %0d: %s got %h, want %h",
                     $time, results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        pio_result_t got;
        pio_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pio_result_t'(m_axis_tdata[70:0]);
            if (pending_results.size() == 0)
                note_mismatch("unexpected beat, read_data", got.read_data, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data)
                    note_mismatch("read_data", got.read_data, want.read_data);
                if (got.frame_sent !== want.frame_sent)
                    note_mismatch("frame_sent", 32'(got.frame_sent), 32'(want.frame_sent));
                if (got.frame_word !== want.frame_word)
                    note_mismatch("frame_word", got.frame_word, want.frame_word);
                if (got.frame_length !== want.frame_length)
                    note_mismatch("frame_length", 32'(got.frame_length),
                                  32'(want.frame_length));
                if (got.deselect !== want.deselect)
                    note_mismatch("deselect", 32'(got.deselect), 32'(want.deselect));
                if (got.rx_overflow !== want.rx_overflow)
                    note_mismatch("rx_overflow", 32'(got.rx_overflow), 32'(want.rx_overflow));
                if (got.unmapped !== want.unmapped)
                    note_mismatch("unmapped", 32'(got.unmapped), 32'(want.unmapped));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        ctrl0_q    = CMD_MODE_CTRL;
        ctrl1_q    = '0;
        enable_q   = '0;
        spi_ctrl_q = '0;
        rx_head    = 0;
        rx_fill    = 0;
        for (int i = 0; i < NUM_MISC; i++)
            misc_q[i] = '0;
        for (int i = 0; i < DEF_FIFO_DEPTH; i++)
            rx_mem[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_rx_overflow();
        test_backpressure();
        test_random_traffic();

        // pipeline is two deep; wait on past that to catch any stray beats
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("spi_controller_pio_registers_unit test passed");
        else
            $display("spi_controller_pio_registers_unit test failed");
        $finish;
    end

endmodule
